// ----- rtl/decimal_criss_cross_multiplier_macros.svh -----
// Assertion macros used by the decimal criss-cross multiplier top level.
`ifndef DECIMAL_CRISS_CROSS_MULTIPLIER_MACROS_SVH
`define DECIMAL_CRISS_CROSS_MULTIPLIER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCCM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DCCM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dccm_pkg.sv -----
// Shared widths, constants and the column tag type of the decimal multiplier.
package dccm_pkg;

  localparam int unsigned BCD_W   = 64;  // packed BCD operand width
  localparam int unsigned CNT_W   = 5;   // digit count width
  localparam int unsigned DIGIT_W = 4;   // one BCD nibble
  localparam int unsigned POS_W   = 5;   // product digit position

  // Group of four digit products: 4 * 15 * 15 = 900 fits in 10 bits.
  localparam int unsigned GRP_DIGITS = 4;
  localparam int unsigned PART_W     = 10;

  // Column sum: at most 16 * 225 plus a carry of at most 400.
  localparam int unsigned SUM_W   = 13;
  localparam int unsigned CARRY_W = 10;

  // Divide by ten as (sum * 6554) >> 16, exact for sums below 16384.
  localparam int unsigned RECIP_W     = 14;
  localparam int unsigned RECIP_10    = 6554;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned DECIMAL_BASE = 10;

  // Tag that travels with one column through the sum stage.
  typedef struct packed {
    logic              vld;       // column entry present
    logic              extra;     // final-carry slot after the last column
    logic              last_col;  // last regular column
    logic [POS_W-1:0]  col;       // column index
  } col_tag_t;

endpackage

// ----- rtl/dccm_chan_if.sv -----
// Valid/ready channel interfaces for operand items and product digits.
interface dccm_in_if;
  logic                          valid;
  logic                          ready;
  logic [dccm_pkg::BCD_W-1:0]    multiplicand_bcd;
  logic [dccm_pkg::CNT_W-1:0]    multiplicand_digits;
  logic [dccm_pkg::BCD_W-1:0]    multiplier_bcd;
  logic [dccm_pkg::CNT_W-1:0]    multiplier_digits;

  modport source (
    output valid, multiplicand_bcd, multiplicand_digits, multiplier_bcd, multiplier_digits,
    input  ready
  );
  modport sink (
    input  valid, multiplicand_bcd, multiplicand_digits, multiplier_bcd, multiplier_digits,
    output ready
  );
endinterface

interface dccm_out_if;
  logic                          valid;
  logic                          ready;
  logic [dccm_pkg::DIGIT_W-1:0]  product_digit;
  logic [dccm_pkg::POS_W-1:0]    digit_position;
  logic                          last_digit;

  modport source (
    output valid, product_digit, digit_position, last_digit,
    input  ready
  );
  modport sink (
    input  valid, product_digit, digit_position, last_digit,
    output ready
  );
endinterface

// ----- rtl/dccm_col_sum.sv -----
// Column partial-sum stage: digit products of one column, summed in groups of four.
module dccm_col_sum #(
  parameter int unsigned DIGITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  dccm_pkg::col_tag_t                tag_in,
  input  logic [DIGITS*dccm_pkg::DIGIT_W-1:0] a_dig,
  input  logic [DIGITS*dccm_pkg::DIGIT_W-1:0] w_dig,
  output dccm_pkg::col_tag_t                tag_r,
  output logic [((DIGITS+dccm_pkg::GRP_DIGITS-1)/dccm_pkg::GRP_DIGITS)-1:0]
               [dccm_pkg::PART_W-1:0]       part_r
);

  localparam int unsigned NGRP  = (DIGITS + dccm_pkg::GRP_DIGITS - 1) / dccm_pkg::GRP_DIGITS;
  localparam int unsigned PAD_W = NGRP * dccm_pkg::GRP_DIGITS * dccm_pkg::DIGIT_W;

  logic [PAD_W-1:0]                    a_pad;
  logic [PAD_W-1:0]                    w_pad;
  logic [NGRP-1:0][dccm_pkg::PART_W-1:0] part_nxt;

  // Pad both digit vectors to whole groups with zero digits
  assign a_pad = PAD_W'(a_dig);
  assign w_pad = PAD_W'(w_dig);

  // Multiply aligned digit pairs and add four products per group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      part_nxt[g] = '0;
      for (int j = 0; j < dccm_pkg::GRP_DIGITS; j++) begin
        part_nxt[g] = part_nxt[g]
          + dccm_pkg::PART_W'(a_pad[(g*dccm_pkg::GRP_DIGITS+j)*dccm_pkg::DIGIT_W +: dccm_pkg::DIGIT_W])
          * dccm_pkg::PART_W'(w_pad[(g*dccm_pkg::GRP_DIGITS+j)*dccm_pkg::DIGIT_W +: dccm_pkg::DIGIT_W]);
      end
    end
  end

  // Advance the tag with the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (adv) begin
      tag_r <= tag_in;
    end
  end

  // Hold the group sums
  always_ff @(posedge clk) begin
    if (adv) begin
      part_r <= part_nxt;
    end
  end

endmodule

// ----- rtl/decimal_criss_cross_multiplier.sv -----
// Top level of the decimal criss-cross multiplier: column sequencer, carry stage, output.
//
//  channel | dir | handshake           | payload
//  in_ch   | in  | valid / ready       | multiplicand_bcd, multiplicand_digits,
//          |     |                     | multiplier_bcd, multiplier_digits
//  out_ch  | out | valid / ready       | product_digit, digit_position, last_digit
//
// An item with la and lb digits occupies the column sequencer for the load, then la + lb - 1
// columns, one per cycle while out_ch does not stall, then the final-carry slot; in_ch.ready
// rises again after that.
// The multiplier digits walk one digit per cycle through a shift register window, holding while out_ch stalls.
// The first product digit passes the column-sum and output registers; then one per cycle unless out_ch stalls.
// A stall on out_ch freezes both pipeline stages and the sequencer.
// Reset is synchronous, active low, and clears the sequencer and all valid flags.
module decimal_criss_cross_multiplier #(
  parameter int unsigned DIGITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  dccm_in_if.sink      in_ch,
  dccm_out_if.source   out_ch
);

`include "decimal_criss_cross_multiplier_macros.svh"

  localparam int unsigned DW   = DIGITS * dccm_pkg::DIGIT_W;
  localparam int unsigned NGRP = (DIGITS + dccm_pkg::GRP_DIGITS - 1) / dccm_pkg::GRP_DIGITS;
  localparam int unsigned PROD_W = dccm_pkg::SUM_W + dccm_pkg::RECIP_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                         state_r;
  logic [DW-1:0]                  a_r;
  logic [DW-1:0]                  w_r;
  logic [DW-1:0]                  bsh_r;
  logic [dccm_pkg::CNT_W-1:0]     cols_r;
  logic [dccm_pkg::POS_W-1:0]     k_r;
  logic [dccm_pkg::CARRY_W-1:0]   carry_r;

  logic                           out_vld_r;
  logic [dccm_pkg::DIGIT_W-1:0]   out_digit_r;
  logic [dccm_pkg::POS_W-1:0]     out_pos_r;
  logic                           out_last_r;

  logic                           adv;
  logic                           in_xfer;
  logic                           issue;
  logic [dccm_pkg::CNT_W-1:0]     la;
  logic [dccm_pkg::CNT_W-1:0]     lb;
  logic [DW-1:0]                  a_ld;
  logic [DW-1:0]                  b_ld;
  dccm_pkg::col_tag_t             tag_in;
  dccm_pkg::col_tag_t             col_tag;
  logic [NGRP-1:0][dccm_pkg::PART_W-1:0] part;

  logic [dccm_pkg::CARRY_W-1:0]   carry_in;
  logic [dccm_pkg::SUM_W-1:0]     sum;
  logic [PROD_W-1:0]              recip_prod;
  logic [dccm_pkg::CARRY_W-1:0]   quot;
  logic [dccm_pkg::SUM_W-1:0]     rem;

  // Saturate a digit count into 1..DIGITS
  function automatic logic [dccm_pkg::CNT_W-1:0] clamp_len(
    input logic [dccm_pkg::CNT_W-1:0] n
  );
    logic [dccm_pkg::CNT_W-1:0] res;
    res = n;
    if (n == '0) begin
      res = dccm_pkg::CNT_W'(1);
    end else if (n > dccm_pkg::CNT_W'(DIGITS)) begin
      res = dccm_pkg::CNT_W'(DIGITS);
    end
    return res;
  endfunction

  assign adv     = !out_vld_r || out_ch.ready;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign issue   = (state_r == ST_RUN) && adv;

  assign in_ch.ready = (state_r == ST_IDLE);

  // Clamp counts and drop digits above them
  assign la = clamp_len(in_ch.multiplicand_digits);
  assign lb = clamp_len(in_ch.multiplier_digits);

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      a_ld[i*dccm_pkg::DIGIT_W +: dccm_pkg::DIGIT_W] =
        (dccm_pkg::CNT_W'(i) < la) ? in_ch.multiplicand_bcd[i*dccm_pkg::DIGIT_W +: dccm_pkg::DIGIT_W]
                                   : '0;
      b_ld[i*dccm_pkg::DIGIT_W +: dccm_pkg::DIGIT_W] =
        (dccm_pkg::CNT_W'(i) < lb) ? in_ch.multiplier_bcd[i*dccm_pkg::DIGIT_W +: dccm_pkg::DIGIT_W]
                                   : '0;
    end
  end

  // Tag the column being issued
  always_comb begin
    tag_in.vld      = issue;
    tag_in.extra    = (k_r == dccm_pkg::POS_W'(cols_r));
    tag_in.last_col = (k_r == dccm_pkg::POS_W'(cols_r - dccm_pkg::CNT_W'(1)));
    tag_in.col      = k_r;
  end

  // Column sequencer: load operands, then walk the multiplier window one digit per column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            state_r <= ST_RUN;
            k_r     <= '0;
          end
        end
        ST_RUN: begin
          if (issue) begin
            k_r <= k_r + dccm_pkg::POS_W'(1);
            if (tag_in.extra) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Operand and window shift registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_r    <= a_ld;
      w_r    <= DW'(b_ld[dccm_pkg::DIGIT_W-1:0]);
      bsh_r  <= b_ld >> dccm_pkg::DIGIT_W;
      cols_r <= la + lb - dccm_pkg::CNT_W'(1);
    end else if (issue) begin
      w_r    <= DW'({w_r, bsh_r[dccm_pkg::DIGIT_W-1:0]});
      bsh_r  <= bsh_r >> dccm_pkg::DIGIT_W;
    end
  end

  dccm_col_sum #(
    .DIGITS (DIGITS)
  ) u_col_sum (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .tag_in (tag_in),
    .a_dig  (a_r),
    .w_dig  (w_r),
    .tag_r  (col_tag),
    .part_r (part)
  );

  // Add group sums and carry, then split into digit and next carry
  always_comb begin
    carry_in = (col_tag.col == '0) ? '0 : carry_r;
    sum      = dccm_pkg::SUM_W'(carry_in);
    for (int g = 0; g < NGRP; g++) begin
      sum = sum + dccm_pkg::SUM_W'(part[g]);
    end
    recip_prod = PROD_W'(sum) * PROD_W'(dccm_pkg::RECIP_10);
    quot       = recip_prod[dccm_pkg::RECIP_SHIFT +: dccm_pkg::CARRY_W];
    rem        = sum - dccm_pkg::SUM_W'({quot, 3'b000}) - dccm_pkg::SUM_W'({quot, 1'b0});
  end

  // Carry between columns
  always_ff @(posedge clk) begin
    if (adv && col_tag.vld && !col_tag.extra) begin
      carry_r <= quot;
    end
  end

  // Output register: drop the final-carry slot when the carry is zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= col_tag.vld && (!col_tag.extra || (carry_r != '0));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pos_r <= col_tag.col;
      if (col_tag.extra) begin
        out_digit_r <= carry_r[dccm_pkg::DIGIT_W-1:0];
        out_last_r  <= 1'b1;
      end else begin
        out_digit_r <= rem[dccm_pkg::DIGIT_W-1:0];
        out_last_r  <= col_tag.last_col && (quot == '0);
      end
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.product_digit  = out_digit_r;
  assign out_ch.digit_position = out_pos_r;
  assign out_ch.last_digit     = out_last_r;

  // Checks on sequencer and divide-by-ten datapath
  `DCCM_ASSERT_NXT(a_load_starts_run, clk, rst_n, in_xfer, state_r == ST_RUN, "load did not start column run")
  `DCCM_ASSERT_IMPL(a_col_in_range, clk, rst_n, state_r == ST_RUN, k_r <= dccm_pkg::POS_W'(cols_r), "column index past final-carry slot")
  `DCCM_ASSERT_IMPL(a_rem_decimal, clk, rst_n, col_tag.vld && !col_tag.extra, rem < dccm_pkg::SUM_W'(dccm_pkg::DECIMAL_BASE), "column remainder not a decimal digit")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the decimal criss-cross multiplier: directed table, then random items.
module testbench;

  localparam int unsigned MAX_DIGITS   = 16;
  localparam int          RANDOM_ITEMS = 200;
  localparam int          DRAIN_CYCLES = 2 * MAX_DIGITS + 8;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          SINK_SPAN    = 97;

  // One operand pair; typed rows carry their product digits, nibble k = position k.
  typedef struct packed {
    logic [dccm_pkg::BCD_W-1:0]  a;
    logic [dccm_pkg::CNT_W-1:0]  la;
    logic [dccm_pkg::BCD_W-1:0]  b;
    logic [dccm_pkg::CNT_W-1:0]  lb;
    logic                        typed;
    logic [5:0]                  n_digits;
    logic [4*2*MAX_DIGITS-1:0]   digits;
  } mul_case_t;

  typedef struct packed {
    logic [dccm_pkg::DIGIT_W-1:0] digit;
    logic [dccm_pkg::POS_W-1:0]   pos;
    logic                         last;
  } product_digit_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_MOSTLY} sink_mode_t;

  localparam mul_case_t DIRECTED [17] = '{
    '{64'h0, 5'd1, 64'h0, 5'd1, 1'b1, 6'd1, 128'h0},
    '{64'h1, 5'd1, 64'h1, 5'd1, 1'b1, 6'd1, 128'h1},
    '{64'h5, 5'd1, 64'h2, 5'd1, 1'b1, 6'd2, 128'h10},
    '{64'h9, 5'd1, 64'h9, 5'd1, 1'b1, 6'd2, 128'h81},
    // full-width nines: every column carries, 32 digits
    '{{16{4'h9}}, 5'd16, {16{4'h9}}, 5'd16, 1'b1, 6'd32,
      128'h9999999999999998_0000000000000001},
    // zero times full-width nines: 31 zero columns, no final carry
    '{64'h0, 5'd16, {16{4'h9}}, 5'd16, 1'b1, 6'd31, 128'h0},
    // zero counts act as one digit, garbage above the count is ignored
    '{64'hFFFF_FFFF_FFFF_FFF7, 5'd0, 64'h1234_5678_9ABC_DEF8, 5'd0, 1'b1, 6'd2, 128'h56},
    // non-decimal nibbles: 15 * 15 = 225
    '{64'hF, 5'd1, 64'hF, 5'd1, 1'b1, 6'd2, 128'h65},
    // 11 * 15 = 165: final carry of 16 leaves a zero top digit
    '{64'hB, 5'd1, 64'hF, 5'd1, 1'b1, 6'd2, 128'h05},
    // untyped rows use predict_product; counts above the limit saturate
    '{64'h1234_5678_9012_3456, 5'd31, 64'h9876_5432_1098_7654, 5'd17, 1'b0, 6'd0, 128'h0},
    '{64'h5555_0000_9999_1111, 5'd16, 64'h0102_0304_0506_0708, 5'd31, 1'b0, 6'd0, 128'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 1'b0, 6'd0, 128'h0},
    '{64'h8765_4321, 5'd8, 64'h1234_5678, 5'd8, 1'b0, 6'd0, 128'h0},
    '{64'h9, 5'd1, {16{4'h9}}, 5'd16, 1'b0, 6'd0, 128'h0},
    '{{16{4'h9}}, 5'd16, 64'h7, 5'd1, 1'b0, 6'd0, 128'h0},
    '{64'h1000_0000_0000_0000, 5'd16, 64'h1, 5'd1, 1'b0, 6'd0, 128'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 5'd24, 64'h9999_9999_9999_9999, 5'd1, 1'b0, 6'd0, 128'h0}
  };

  logic clk;
  logic rst_n;

  dccm_in_if  in_ch ();
  dccm_out_if out_ch ();

  decimal_criss_cross_multiplier #(.DIGITS(MAX_DIGITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  product_digit_t pending_digits[$];
  product_digit_t expected_digit;
  int             error_count;
  int             cycle_count;
  int             burst_left;
  int             sink_phase;

  // Clock generation
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturate a raw digit count into 1..MAX_DIGITS
  function automatic int unsigned digit_count(logic [dccm_pkg::CNT_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_DIGITS) return MAX_DIGITS;
    return raw;
  endfunction

  // Column-wise product: sum diagonal digit products plus carry, emit sum mod 10, then any final carry
  function automatic void predict_product(mul_case_t op);
    int unsigned    la;
    int unsigned    lb;
    int unsigned    cols;
    int unsigned    carry;
    int unsigned    sum;
    product_digit_t tail;
    la    = digit_count(op.la);
    lb    = digit_count(op.lb);
    cols  = la + lb - 1;
    carry = 0;
    for (int unsigned k = 0; k < cols; k++) begin
      sum = carry;
      for (int unsigned i = 0; i < la; i++)
        if (k >= i && k - i < lb) sum += op.a[4*i +: 4] * op.b[4*(k-i) +: 4];
      carry = sum / 10;
      pending_digits.push_back('{digit: dccm_pkg::DIGIT_W'(sum % 10),
                                 pos: dccm_pkg::POS_W'(k), last: 1'b0});
    end
    if (carry != 0)
      pending_digits.push_back('{digit: dccm_pkg::DIGIT_W'(carry),
                                 pos: dccm_pkg::POS_W'(cols), last: 1'b0});
    // flag the most significant digit
    tail = pending_digits.pop_back();
    tail.last = 1'b1;
    pending_digits.push_back(tail);
  endfunction

  // Random operand: mostly decimal digits, some all nines, some raw bits
  function automatic logic [dccm_pkg::BCD_W-1:0] random_operand();
    logic [dccm_pkg::BCD_W-1:0] word;
    int unsigned                pick;
    pick = $urandom_range(0, 99);
    word = '0;
    if (pick < 15) word = {$urandom, $urandom};
    else if (pick < 22) word = {16{4'h9}};
    else for (int i = 0; i < 16; i++) word[4*i +: 4] = 4'($urandom_range(0, 9));
    return word;
  endfunction

  // Random count: mostly short, some full width, some out of range
  function automatic logic [dccm_pkg::CNT_W-1:0] random_count();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return dccm_pkg::CNT_W'($urandom_range(1, 5));
    if (pick < 80) return dccm_pkg::CNT_W'($urandom_range(6, 15));
    if (pick < 90) return dccm_pkg::CNT_W'(MAX_DIGITS);
    return dccm_pkg::CNT_W'($urandom_range(0, 31));
  endfunction

  // Drive one operand pair, hold until the transfer, then record its digits
  task automatic send_operands(input mul_case_t op);
    in_ch.valid               <= 1'b1;
    in_ch.multiplicand_bcd    <= op.a;
    in_ch.multiplicand_digits <= op.la;
    in_ch.multiplier_bcd      <= op.b;
    in_ch.multiplier_digits   <= op.lb;
    do @(posedge clk); while (!in_ch.ready);
    if (op.typed) begin
      for (int k = 0; k < op.n_digits; k++)
        pending_digits.push_back('{digit: op.digits[4*k +: 4], pos: dccm_pkg::POS_W'(k),
                                   last: (k == op.n_digits - 1)});
    end else begin
      predict_product(op);
    end
  endtask

  // End a burst with a random gap; occasionally start a long gapless burst
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 6);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver stall pattern, switching mode as sink_phase passes each multiple of SINK_SPAN
  initial begin
    sink_phase = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      sink_phase++;
      case (sink_mode_t'((sink_phase / SINK_SPAN) % 4))
        SINK_OPEN:   out_ch.ready <= 1'b1;
        SINK_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
        SINK_SPARSE: out_ch.ready <= (sink_phase % 5 == 0);
        default:     out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Compare each product digit transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_digits.size() == 0) begin
        $error("product_digit: expected none, got %0d at position %0d",
               out_ch.product_digit, out_ch.digit_position);
        error_count++;
      end else begin
        expected_digit = pending_digits.pop_front();
        if (out_ch.product_digit !== expected_digit.digit) begin
          $error("product_digit: expected %0d, got %0d",
                 expected_digit.digit, out_ch.product_digit);
          error_count++;
        end
        if (out_ch.digit_position !== expected_digit.pos) begin
          $error("digit_position: expected %0d, got %0d",
                 expected_digit.pos, out_ch.digit_position);
          error_count++;
        end
        if (out_ch.last_digit !== expected_digit.last) begin
          $error("last_digit: expected %0d, got %0d",
                 expected_digit.last, out_ch.last_digit);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAIL decimal_criss_cross_multiplier");
        $finish;
      end
    end
  end

  // Reset, directed table, random items, drain
  initial begin
    mul_case_t op;
    error_count = 0;
    burst_left  = 0;
    rst_n                     <= 1'b0;
    in_ch.valid               <= 1'b0;
    in_ch.multiplicand_bcd    <= '0;
    in_ch.multiplicand_digits <= '0;
    in_ch.multiplier_bcd      <= '0;
    in_ch.multiplier_digits   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[row]) begin
      send_operands(DIRECTED[row]);
      pace_sender();
    end

    for (int item = 0; item < RANDOM_ITEMS; item++) begin
      op    = '0;
      op.a  = random_operand();
      op.la = random_count();
      op.b  = random_operand();
      op.lb = random_count();
      send_operands(op);
      pace_sender();
    end
    in_ch.valid <= 1'b0;

    // wait out outstanding digits, then watch for strays
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS decimal_criss_cross_multiplier");
    end else begin
      $display("FAIL decimal_criss_cross_multiplier");
    end
    $finish;
  end

endmodule
